@@ design/swept_sphere_collision_time_macros.svh @@
// Assertion macros used by the swept sphere collision time top level.
`ifndef SWEPT_SPHERE_COLLISION_TIME_MACROS_SVH
`define SWEPT_SPHERE_COLLISION_TIME_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ssct_pkg.sv @@
// Package with widths, constants and types of the swept sphere collision time block.
`timescale 1ns / 1ps
package ssct_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MIN_SPEED_W   = 20;
  localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RST = 20'd42950;

  localparam int OFS_W  = 25;
  localparam int VEL_W  = 24;
  localparam int RAD_W  = 23;
  localparam int DV_W   = 25;
  localparam int RS_W   = 24;
  localparam int SQ_W   = 49;
  localparam int PR_W   = 50;
  localparam int RR_W   = 48;
  localparam int C_W    = 51;
  localparam int A_W    = 50;
  localparam int NB_W   = 50;
  localparam int HALF_W = NB_W / 2;
  localparam int PP_W   = 2 * HALF_W;
  localparam int PW     = 2 * NB_W;
  localparam int ROOT_W = NB_W;
  localparam int SR_W   = ROOT_W + 2;
  localparam int TIME_W = 32;

  localparam int IN_BITS     = 3 * OFS_W + 6 * VEL_W + 2 * RAD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + TIME_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int VA_OFF = 3 * OFS_W;
  localparam int VB_OFF = VA_OFF + 3 * VEL_W;
  localparam int RA_OFF = VB_OFF + 3 * VEL_W;
  localparam int RB_OFF = RA_OFF + RAD_W;

  // Per-item decision bits that travel beside the datapath.
  typedef struct packed {
    logic vld;
    logic done;
    logic hit;
    logic ovl;
    logic sat;
  } meta_t;

endpackage

@@ design/swept_sphere_collision_time.sv @@
// Top level of the swept sphere collision time pipeline.
// Throughput: one transaction per cycle; 50 square root stages and 32 divide stages set the depth.
// The whole pipeline advances together and holds while the output waits.
// Reset (rst_n low, synchronous) empties the pipeline and sets min_speed_sq to 42950.
`timescale 1ns / 1ps
`include "swept_sphere_collision_time_macros.svh"
module swept_sphere_collision_time #(
  parameter int FRAC_BITS = ssct_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // offset_x, offset_y, offset_z, vel_a_x, vel_a_y, vel_a_z,
  // vel_b_x, vel_b_y, vel_b_z, radius_a, radius_b, zero fill
  input  logic [ssct_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit, overlapping, time_to_hit, zero fill
  output logic [ssct_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssct_pkg::MIN_SPEED_W-1:0]   cfg_data
);
  import ssct_pkg::*;

  localparam int SH   = TIME_W - FRAC_BITS;
  localparam int R0_W = NB_W - SH;
  localparam int DV_N = TIME_W;

  logic en;
  logic [MIN_SPEED_W-1:0] min_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_SPEED_RST;
    end else if (cfg_valid) begin
      min_r <= cfg_data;
    end
  end

  // Stage 1: relative velocity and radius sum.
  logic signed [OFS_W-1:0] s_nxt [3];
  logic signed [DV_W-1:0]  v_nxt [3];
  logic [RS_W-1:0]         r_nxt;
  logic signed [OFS_W-1:0] s_r [3];
  logic signed [DV_W-1:0]  v_r [3];
  logic [RS_W-1:0]         r_r;
  logic                    vld1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = in_tdata[i*OFS_W +: OFS_W];
      v_nxt[i] = DV_W'($signed(in_tdata[VA_OFF + i*VEL_W +: VEL_W]))
               - DV_W'($signed(in_tdata[VB_OFF + i*VEL_W +: VEL_W]));
    end
    r_nxt = RS_W'(in_tdata[RA_OFF +: RAD_W]) + RS_W'(in_tdata[RB_OFF +: RAD_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  // Stage 2: the ten products of the three dot products and r*r.
  logic signed [PR_W-1:0] ssp [3];
  logic signed [PR_W-1:0] vvp [3];
  logic signed [PR_W-1:0] vsp [3];
  logic [SQ_W-1:0]        ss_r [3];
  logic [SQ_W-1:0]        vv_r [3];
  logic signed [PR_W-1:0] vs_r [3];
  logic [RR_W-1:0]        rr_r;
  logic                   vld2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ssp[i] = PR_W'(s_r[i]) * PR_W'(s_r[i]);
      vvp[i] = PR_W'(v_r[i]) * PR_W'(v_r[i]);
      vsp[i] = PR_W'(v_r[i]) * PR_W'(s_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ss_r[i] <= ssp[i][SQ_W-1:0];
        vv_r[i] <= vvp[i][SQ_W-1:0];
        vs_r[i] <= vsp[i];
      end
      rr_r <= RR_W'(r_r) * RR_W'(r_r);
    end
  end

  // Stage 3: c = s.s - r*r, a = v.v, b = v.s.
  logic [C_W-1:0] c_r;
  logic [C_W-1:0] b_r;
  logic [A_W-1:0] a3_r;
  logic           vld3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r  <= C_W'(ss_r[0]) + C_W'(ss_r[1]) + C_W'(ss_r[2]) - C_W'(rr_r);
      b_r  <= C_W'(vs_r[0]) + C_W'(vs_r[1]) + C_W'(vs_r[2]);
      a3_r <= A_W'(vv_r[0]) + A_W'(vv_r[1]) + A_W'(vv_r[2]);
    end
  end

  // Stage 4: early decisions (overlap, no or too slow motion, separating).
  meta_t          meta4_nxt, meta4_r;
  logic [C_W-1:0] nb_full;
  logic [NB_W-1:0] nb4_r;
  logic [NB_W-1:0] cu4_r;
  logic [A_W-1:0]  a4_r;

  always_comb begin
    meta4_nxt = '0;
    meta4_nxt.vld = vld3_r;
    if (c_r[C_W-1]) begin
      meta4_nxt.done = 1'b1;
      meta4_nxt.hit  = 1'b1;
      meta4_nxt.ovl  = 1'b1;
    end else if (a3_r == '0 || a3_r < A_W'(min_r) || !b_r[C_W-1]) begin
      meta4_nxt.done = 1'b1;
    end
    nb_full = C_W'(0) - b_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb4_r <= nb_full[NB_W-1:0];
      cu4_r <= c_r[NB_W-1:0];
      a4_r  <= a3_r;
    end
  end

  // Stage 5: partial products of b*b and a*c on halves.
  logic [PP_W-1:0] bhh_r, bhl_r, bll_r, ahh_r, ahl_r, alh_r, all_r;
  logic [A_W-1:0]  a5_r;
  logic [NB_W-1:0] nb5_r;
  meta_t           meta5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bhh_r <= PP_W'(nb4_r[NB_W-1:HALF_W]) * PP_W'(nb4_r[NB_W-1:HALF_W]);
      bhl_r <= PP_W'(nb4_r[NB_W-1:HALF_W]) * PP_W'(nb4_r[HALF_W-1:0]);
      bll_r <= PP_W'(nb4_r[HALF_W-1:0]) * PP_W'(nb4_r[HALF_W-1:0]);
      ahh_r <= PP_W'(a4_r[A_W-1:HALF_W]) * PP_W'(cu4_r[NB_W-1:HALF_W]);
      ahl_r <= PP_W'(a4_r[A_W-1:HALF_W]) * PP_W'(cu4_r[HALF_W-1:0]);
      alh_r <= PP_W'(a4_r[HALF_W-1:0]) * PP_W'(cu4_r[NB_W-1:HALF_W]);
      all_r <= PP_W'(a4_r[HALF_W-1:0]) * PP_W'(cu4_r[HALF_W-1:0]);
      a5_r  <= a4_r;
      nb5_r <= nb4_r;
    end
  end

  // Stage 6: assemble b*b and a*c.
  logic [PW-1:0]   bb6_r, ac6_r;
  logic [A_W-1:0]  a6_r;
  logic [NB_W-1:0] nb6_r;
  meta_t           meta6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bb6_r <= (PW'(bhh_r) << (2*HALF_W)) + (PW'(bhl_r) << (HALF_W+1)) + PW'(bll_r);
      ac6_r <= (PW'(ahh_r) << (2*HALF_W)) + ((PW'(ahl_r) + PW'(alh_r)) << HALF_W)
             + PW'(all_r);
      a6_r  <= a5_r;
      nb6_r <= nb5_r;
    end
  end

  // Stage 7 feeds the square root: discriminant and its sign.
  logic [PW:0] disc;
  meta_t       meta7_nxt;

  logic [PW-1:0]   sq_d_r    [0:ROOT_W];
  logic [SR_W-1:0] sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [0:ROOT_W];
  logic [A_W-1:0]  sq_a_r    [0:ROOT_W];
  logic [NB_W-1:0] sq_nb_r   [0:ROOT_W];
  meta_t           sq_meta_r [0:ROOT_W];

  always_comb begin
    disc = {1'b0, bb6_r} - {1'b0, ac6_r};
    meta7_nxt = meta6_r;
    if (!meta6_r.done && disc[PW]) begin
      meta7_nxt.done = 1'b1;
      meta7_nxt.hit  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d_r[0]    <= disc[PW-1:0];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_a_r[0]    <= a6_r;
      sq_nb_r[0]   <= nb6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r       <= 1'b0;
      vld2_r       <= 1'b0;
      vld3_r       <= 1'b0;
      meta4_r      <= '0;
      meta5_r      <= '0;
      meta6_r      <= '0;
      sq_meta_r[0] <= '0;
    end else if (en) begin
      vld1_r       <= in_tvalid;
      vld2_r       <= vld1_r;
      vld3_r       <= vld2_r;
      meta4_r      <= meta4_nxt;
      meta5_r      <= meta4_r;
      meta6_r      <= meta5_r;
      sq_meta_r[0] <= meta7_nxt;
    end
  end

  // Square root, one result bit per stage, two radicand bits taken in each.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [SR_W-1:0] rsh;
    logic [SR_W-1:0] trial;
    logic [SR_W:0]   dif;
    logic            ge;

    assign rsh   = {sq_rem_r[k][SR_W-3:0], sq_d_r[k][PW-1:PW-2]};
    assign trial = {sq_root_r[k], 2'b01};
    assign dif   = {1'b0, rsh} - {1'b0, trial};
    assign ge    = !dif[SR_W];

    always_ff @(posedge clk) begin
      if (en) begin
        sq_d_r[k+1]    <= {sq_d_r[k][PW-3:0], 2'b00};
        sq_rem_r[k+1]  <= ge ? dif[SR_W-1:0] : rsh;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_a_r[k+1]    <= sq_a_r[k];
        sq_nb_r[k+1]   <= sq_nb_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_meta_r[k+1] <= '0;
      end else if (en) begin
        sq_meta_r[k+1] <= sq_meta_r[k];
      end
    end
  end

  // Numerator -b - sqrt(d).
  logic [NB_W-1:0] num_r;
  logic [A_W-1:0]  an_r;
  meta_t           metan_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= sq_nb_r[ROOT_W] - sq_root_r[ROOT_W];
      an_r  <= sq_a_r[ROOT_W];
    end
  end

  // Divider setup: the quotient saturates when num >= a * 2^(32 - FRAC_BITS).
  logic [R0_W-1:0] r0;
  logic            sat;
  meta_t           metap_nxt;

  logic [A_W-1:0]    dv_rem_r  [0:DV_N];
  logic [TIME_W-1:0] dv_low_r  [0:DV_N];
  logic [TIME_W-1:0] dv_q_r    [0:DV_N];
  logic [A_W-1:0]    dv_a_r    [0:DV_N];
  meta_t             dv_meta_r [0:DV_N];

  always_comb begin
    r0  = num_r[NB_W-1:SH];
    sat = A_W'(r0) >= an_r;
    metap_nxt = metan_r;
    metap_nxt.sat = sat && !metan_r.done;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= A_W'(r0);
      dv_low_r[0] <= {num_r[SH-1:0], {FRAC_BITS{1'b0}}};
      dv_q_r[0]   <= '0;
      dv_a_r[0]   <= an_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metan_r      <= '0;
      dv_meta_r[0] <= '0;
    end else if (en) begin
      metan_r      <= sq_meta_r[ROOT_W];
      dv_meta_r[0] <= metap_nxt;
    end
  end

  // Restoring divide, one quotient bit per stage.
  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [A_W:0] rsh;
    logic [A_W:0] dif;
    logic         ge;

    assign rsh = {dv_rem_r[j], dv_low_r[j][TIME_W-1]};
    assign dif = rsh - {1'b0, dv_a_r[j]};
    assign ge  = !dif[A_W];

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= ge ? dif[A_W-1:0] : rsh[A_W-1:0];
        dv_low_r[j+1] <= {dv_low_r[j][TIME_W-2:0], 1'b0};
        dv_q_r[j+1]   <= {dv_q_r[j][TIME_W-2:0], ge};
        dv_a_r[j+1]   <= dv_a_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_meta_r[j+1] <= '0;
      end else if (en) begin
        dv_meta_r[j+1] <= dv_meta_r[j];
      end
    end
  end

  // Output register.
  logic              out_vld_r;
  logic              out_hit_r;
  logic              out_ovl_r;
  logic [TIME_W-1:0] out_time_r;
  meta_t             mo;

  assign mo = dv_meta_r[DV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= mo.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= mo.done ? mo.hit : 1'b1;
      out_ovl_r <= mo.ovl;
      if (mo.done) begin
        out_time_r <= '0;
      end else if (mo.sat) begin
        out_time_r <= '1;
      end else begin
        out_time_r <= dv_q_r[DV_N];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_time_r, out_ovl_r, out_hit_r};

  `SSCT_ASSERT_IMP(a_nohit_zero, out_vld_r && !out_hit_r, out_time_r == '0 && !out_ovl_r, "miss with nonzero time or overlap flag")
  `SSCT_ASSERT_IMP(a_ovl_hit, out_vld_r && out_ovl_r, out_hit_r && out_time_r == '0, "overlap without hit at time zero")
  `SSCT_ASSERT_IMP(a_root_le_nb, sq_meta_r[ROOT_W].vld && !sq_meta_r[ROOT_W].done, sq_root_r[ROOT_W] <= sq_nb_r[ROOT_W], "square root exceeds -b")
  `SSCT_ASSERT_IMP(a_rem_lt_a, mo.vld && !mo.done && !mo.sat, dv_rem_r[DV_N] < dv_a_r[DV_N], "divider remainder not below divisor")
  `SSCT_ASSERT_NXT(a_accept_enters, in_tvalid && in_tready, vld1_r, "accepted transaction missing from first stage")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the swept sphere collision time pipeline.
`timescale 1ns / 1ps
module tb_top;
  import ssct_pkg::*;

  localparam int FRAC = 16;
  localparam int PIPE_LAT = 92;

  typedef struct packed {
    logic [RAD_W-1:0] rad_b;
    logic [RAD_W-1:0] rad_a;
    logic signed [VEL_W-1:0] vb_z;
    logic signed [VEL_W-1:0] vb_y;
    logic signed [VEL_W-1:0] vb_x;
    logic signed [VEL_W-1:0] va_z;
    logic signed [VEL_W-1:0] va_y;
    logic signed [VEL_W-1:0] va_x;
    logic signed [OFS_W-1:0] ofs_z;
    logic signed [OFS_W-1:0] ofs_y;
    logic signed [OFS_W-1:0] ofs_x;
  } sphere_pair_t;

  localparam int PAIR_W = $bits(sphere_pair_t);

  typedef struct packed {
    logic [TIME_W-1:0] time_to_hit;
    logic overlapping;
    logic hit;
  } contact_t;

  class contact_scoreboard;
    contact_t expected_q[$];
    logic [MIN_SPEED_W-1:0] min_speed_sq = MIN_SPEED_RST;
    int mismatches = 0;
    int n_hits = 0, n_overlaps = 0, n_saturated = 0, n_results = 0;

    function contact_t predict_contact(sphere_pair_t p);
      longint s[3], v[3], r, c, a, b;
      logic [127:0] bb, ac, d, root, bitv, num, q;
      contact_t res;
      res = '0;
      s[0] = longint'(p.ofs_x); s[1] = longint'(p.ofs_y); s[2] = longint'(p.ofs_z);
      v[0] = longint'(p.va_x) - longint'(p.vb_x);
      v[1] = longint'(p.va_y) - longint'(p.vb_y);
      v[2] = longint'(p.va_z) - longint'(p.vb_z);
      r = longint'(p.rad_a) + longint'(p.rad_b);
      c = s[0] * s[0] + s[1] * s[1] + s[2] * s[2] - r * r;
      if (c < 0) begin
        res.hit = 1'b1;
        res.overlapping = 1'b1;
        return res;
      end
      a = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (a == 0 || a < longint'(min_speed_sq)) return res;
      b = v[0] * s[0] + v[1] * s[1] + v[2] * s[2];
      if (b >= 0) return res;
      bb = 128'(-b) * 128'(-b);
      ac = 128'(a) * 128'(c);
      if (ac > bb) return res;
      // Floor of the integer square root, one result bit per step.
      d = bb - ac;
      root = '0;
      bitv = 128'(1) << 110;
      while (bitv > d) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (d >= root + bitv) begin
          d = d - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      num = 128'(-b) - root;
      q = num / 128'(a);
      res.hit = 1'b1;
      if ((q >> (32 - FRAC)) != 0) res.time_to_hit = '1;
      else res.time_to_hit = TIME_W'((num << FRAC) / 128'(a));
      return res;
    endfunction

    function void note_input(sphere_pair_t p);
      expected_q.push_back(predict_contact(p));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      contact_t got, exp_c;
      got = contact_t'(data[OUT_BITS-1:0]);
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", data);
        return;
      end
      exp_c = expected_q.pop_front();
      if (got !== exp_c || data[OUT_TDATA_W-1:OUT_BITS] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%0b ovl=%0b t=%h  got hit=%0b ovl=%0b t=%h fill=%h",
                   exp_c.hit, exp_c.overlapping, exp_c.time_to_hit, got.hit,
                   got.overlapping, got.time_to_hit, data[OUT_TDATA_W-1:OUT_BITS]);
      end
      if (exp_c.hit) n_hits++;
      if (exp_c.overlapping) n_overlaps++;
      if (exp_c.hit && exp_c.time_to_hit == '1) n_saturated++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MIN_SPEED_W-1:0] cfg_data = '0;

  contact_scoreboard sb = new();
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  swept_sphere_collision_time u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= recv_steady ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  function automatic sphere_pair_t make_pair(int ox, int oy, int oz, int vax, int vay,
                                             int vaz, int vbx, int vby, int vbz,
                                             int ra, int rb);
    sphere_pair_t p;
    p.ofs_x = OFS_W'(ox); p.ofs_y = OFS_W'(oy); p.ofs_z = OFS_W'(oz);
    p.va_x = VEL_W'(vax); p.va_y = VEL_W'(vay); p.va_z = VEL_W'(vaz);
    p.vb_x = VEL_W'(vbx); p.vb_y = VEL_W'(vby); p.vb_z = VEL_W'(vbz);
    p.rad_a = RAD_W'(ra); p.rad_b = RAD_W'(rb);
    return p;
  endfunction

  // Signed random value spanning the given number of bits.
  function automatic int rand_signed(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  function automatic sphere_pair_t random_pair();
    sphere_pair_t p;
    int sel, k, m;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom});
    end else if (sel < 80) begin
      // Mostly approaching pairs, so the root and divide paths are exercised.
      k = $urandom_range(10, 25);
      m = $urandom_range(0, 8);
      p.ofs_x = OFS_W'(rand_signed(k));
      p.ofs_y = OFS_W'(rand_signed(k));
      p.ofs_z = OFS_W'(rand_signed(k));
      p.rad_a = RAD_W'($urandom_range(0, 1 << (k - 2)));
      p.rad_b = RAD_W'($urandom_range(0, 1 << (k - 2)));
      p.vb_x = VEL_W'(rand_signed(18));
      p.vb_y = VEL_W'(rand_signed(18));
      p.vb_z = VEL_W'(rand_signed(18));
      p.va_x = VEL_W'(p.vb_x - (p.ofs_x >>> (m + 1)) + rand_signed(k - 4));
      p.va_y = VEL_W'(p.vb_y - (p.ofs_y >>> (m + 1)) + rand_signed(k - 4));
      p.va_z = VEL_W'(p.vb_z - (p.ofs_z >>> (m + 1)) + rand_signed(k - 4));
    end else begin
      p = make_pair(rand_signed(13), rand_signed(13), rand_signed(13), rand_signed(12),
                    rand_signed(12), rand_signed(12), rand_signed(12), rand_signed(12),
                    rand_signed(12), $urandom_range(0, 2048), $urandom_range(0, 2048));
    end
    return p;
  endfunction

  task automatic send_pair(sphere_pair_t p);
    if (!send_steady && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(p);
    do @(posedge clk); while (!in_tready);
    sb.note_input(p);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_min_speed(logic [MIN_SPEED_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.min_speed_sq = value;
  endtask

  initial begin
    logic [MIN_SPEED_W-1:0] settings[4];
    int one;
    one = 1 << 16;
    settings[0] = MIN_SPEED_RST;
    settings[1] = '0;
    settings[2] = '1;
    settings[3] = MIN_SPEED_W'($urandom_range(1, 1048574));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners under the reset threshold.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_pair(make_pair(2 * one, 0, 0, -one, 0, 0, 0, 0, 0, one, one));
    send_pair(make_pair(4 * one, 0, 0, one, 0, 0, 0, 0, 0, one, one));
    send_pair(make_pair(4 * one, 0, 0, -100, 0, 0, 0, 0, 0, one, one));
    send_pair(make_pair(10 * one, 5 * one, 0, -one, 0, 0, 0, 0, 0, one / 2, one / 2));
    send_pair(make_pair(10 * one, 0, 0, -one, 0, 0, 0, 0, 0, one, one));
    send_pair(make_pair(16777215, 0, 0, -208, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(16777215, 16777215, 16777215, 8388607, 8388607, 8388607,
                        8388607, 8388607, 8388607, 8388607, 8388607));
    send_pair(make_pair(-16777216, -16777216, -16777216, -8388608, -8388608, -8388608,
                        -8388608, -8388608, -8388608, 0, 0));
    send_pair(make_pair(-16777216, -16777216, -16777216, 8388607, 8388607, 8388607,
                        -8388608, -8388608, -8388608, 0, 0));
    send_pair(make_pair(16777215, 0, 0, -8388608, 0, 0, 8388607, 0, 0, 8388607, 0));
    send_pair(make_pair(3 * one, 4 * one, 0, -3, -4, 0, 0, 0, 0, 0, one));

    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        wait_drained();
        write_min_speed(settings[ph]);
        // Separated pair with equal velocities: no relative motion regardless of threshold.
        send_pair(make_pair(5 * one, 0, 0, 7, 0, 0, 7, 0, 0, one, one));
      end
      send_steady = (ph == 2);
      recv_steady = (ph == 2);
      for (int i = 0; i < 234; i++) begin
        if (ph == 1 && i == 117) wait_drained();
        send_pair(random_pair());
      end
      send_steady = 1'b0;
      recv_steady = 1'b0;
    end
    wait_drained();

    $display("Covered %0d results: %0d hits, %0d overlapping, %0d saturated times.",
             sb.n_results, sb.n_hits, sb.n_overlaps, sb.n_saturated);
    $display("Speed thresholds swept: reset, zero, full scale and %0d.", settings[3]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
